// ----- design/ils_pkg.sv -----
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants for the indexed list store
// Command codes, transfer payload structs, cell control and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

    // Default number of cells, and the width of every internal position.
    // IDX_W covers any depth up to 1024 as well as the 7-bit position field.
    localparam int ILS_DEPTH = 64;
    localparam int IDX_W     = 11;

    typedef enum logic [3:0] {
        CMD_INSERT_AT   = 4'd0,
        CMD_INSERT_HEAD = 4'd1,
        CMD_INSERT_TAIL = 4'd2,
        CMD_REMOVE_AT   = 4'd3,
        CMD_REMOVE_HEAD = 4'd4,
        CMD_REMOVE_TAIL = 4'd5,
        CMD_REPLACE_AT  = 4'd6,
        CMD_READ_AT     = 4'd7,
        CMD_EXISTS      = 4'd8,
        CMD_EQUALS      = 4'd9,
        CMD_CLEAR       = 4'd10
    } t_cmd;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_WRITE
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_REDUCE
    } t_state;

    typedef struct packed {
        logic [3:0]         command;
        logic [6:0]         position;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic               ok;
        logic               found;
        logic signed [31:0] read_value;
        logic [6:0]         count;
        logic               empty_res;
    } t_out;

    // Broadcast to every cell of the row.
    typedef struct packed {
        t_cell_op           op;
        logic [IDX_W-1:0]   pos;
        logic [IDX_W-1:0]   count;
        logic               probe_any;
        logic signed [31:0] value;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- design/ils_cell.sv -----
// ----------------------------------------------------------------------------
// ils_cell: one position of the list
// Holds one entry, takes its neighbour's entry when the list shifts, and
// registers its own compare and read results for the reduction stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_cell
    import ils_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  wire                      i_clk,
    input  wire t_cell_ctl           i_ctl,
    input  wire logic signed [31:0]  i_left,
    input  wire logic signed [31:0]  i_right,
    output logic signed [31:0]       o_data,
    output logic                     o_hit,
    output logic signed [31:0]       o_rd
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;
    logic               r_hit;
    logic               n_hit;
    logic signed [31:0] r_rd;
    logic signed [31:0] n_rd;
    logic               at_pos;
    logic               above_pos;
    logic               same;

    assign at_pos    = (MY_IDX == i_ctl.pos);
    assign above_pos = (MY_IDX > i_ctl.pos);
    assign same      = (r_data == i_ctl.value);

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            OP_INSERT: begin
                if (above_pos) begin
                    n_data = i_left;
                end else if (at_pos) begin
                    n_data = i_ctl.value;
                end
            end
            OP_REMOVE: begin
                if (above_pos || at_pos) begin
                    n_data = i_right;
                end
            end
            OP_WRITE: begin
                if (at_pos) begin
                    n_data = i_ctl.value;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    // Compare and read results are taken from the entry before any update.
    always_comb begin
        if (i_ctl.probe_any) begin
            n_hit = same && (MY_IDX < i_ctl.count);
        end else begin
            n_hit = same && at_pos;
        end
        n_rd = at_pos ? r_data : 32'sd0;
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_hit  <= n_hit;
        r_rd   <= n_rd;
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;
    assign o_rd   = r_rd;

endmodule

`default_nettype wire

// ----- design/indexed_list_store.sv -----
// ----------------------------------------------------------------------------
// indexed_list_store: ordered list of signed 32-bit values with indexed access
// A row of cells, one per position, updated together under a small sequencer.
// ----------------------------------------------------------------------------
// Usage: drive i_cmd and raise start while busy is low; the command transfer
// happens at that clock edge. One result comes back on o_res, qualified by
// o_done for exactly one cycle; the receiver cannot hold it off.
// The command is first applied to the row of cells (shift, write, per-cell
// compare) in the apply state; the reduce state then ORs the registered
// per-cell compare and read results into the answer, raising o_done.
// busy is high only in the apply cycle, so a new command may be transferred
// while a result is being presented.
// Reset (synchronous, active low) empties the list and returns the sequencer
// to idle; stored entries are not cleared, since only positions below the
// count are ever read.
// Commands that are out of range, remove from an empty list or insert into a
// full one leave the list unchanged and report ok low.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_store
    import ils_pkg::*;
#(
    parameter int DEPTH = ILS_DEPTH
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       start,
    input  wire t_in  i_cmd,
    output logic      busy,
    output logic      o_done,
    output t_out      o_res
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    t_state             r_state;
    t_state             n_state;
    t_in                r_in;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_ok;
    logic               n_ok;
    logic               r_found_en;
    logic               n_found_en;
    logic               r_rd_en;
    logic               n_rd_en;
    t_cell_ctl          ctl;
    logic [IDX_W-1:0]   cnt_w;
    logic [IDX_W-1:0]   pos_w;
    logic               full;
    logic               accept;
    logic               apply;

    logic signed [31:0] cell_data [DEPTH];
    logic signed [31:0] cell_rd   [DEPTH];
    logic [DEPTH-1:0]   cell_hit;
    logic signed [31:0] rd_any;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   n_state = (start) ? ST_APPLY : ST_IDLE;
            ST_APPLY:  n_state = ST_REDUCE;
            ST_REDUCE: n_state = (start) ? ST_APPLY : ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy   = 1'b0;
        o_done = 1'b0;
        apply  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_APPLY: begin
                busy  = 1'b1;
                apply = 1'b1;
            end
            ST_REDUCE: begin
                o_done = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_cmd;
        end
    end

    // ---------------- command decode ----------------
    assign cnt_w = IDX_W'(r_count);
    assign pos_w = IDX_W'(r_in.position);
    assign full  = (cnt_w == IDX_W'(DEPTH));

    always_comb begin
        n_ok          = 1'b0;
        n_found_en    = 1'b0;
        n_rd_en       = 1'b0;
        n_count       = r_count;
        ctl.op        = OP_NONE;
        ctl.pos       = pos_w;
        ctl.count     = cnt_w;
        ctl.probe_any = 1'b0;
        ctl.value     = r_in.value;
        unique case (t_cmd'(r_in.command))
            CMD_INSERT_AT: begin
                n_ok = !full && (pos_w <= cnt_w);
            end
            CMD_INSERT_HEAD: begin
                n_ok    = !full;
                ctl.pos = '0;
            end
            CMD_INSERT_TAIL: begin
                n_ok    = !full;
                ctl.pos = cnt_w;
            end
            CMD_REMOVE_AT: begin
                n_ok = (pos_w < cnt_w);
            end
            CMD_REMOVE_HEAD: begin
                n_ok    = (cnt_w != '0);
                ctl.pos = '0;
            end
            CMD_REMOVE_TAIL: begin
                n_ok    = (cnt_w != '0);
                ctl.pos = cnt_w - IDX_W'(1);
            end
            CMD_REPLACE_AT: begin
                n_ok = (pos_w < cnt_w);
            end
            CMD_READ_AT: begin
                n_ok       = (pos_w < cnt_w);
                n_found_en = n_ok;
                n_rd_en    = n_ok;
            end
            CMD_EXISTS: begin
                n_ok          = (cnt_w != '0);
                n_found_en    = n_ok;
                ctl.probe_any = 1'b1;
            end
            CMD_EQUALS: begin
                n_ok       = (pos_w < cnt_w);
                n_found_en = n_ok;
            end
            CMD_CLEAR: begin
                n_ok    = 1'b1;
                n_count = '0;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase

        if (apply && n_ok) begin
            case (t_cmd'(r_in.command)) inside
                CMD_INSERT_AT, CMD_INSERT_HEAD, CMD_INSERT_TAIL: begin
                    ctl.op  = OP_INSERT;
                    n_count = CNT_W'(cnt_w + IDX_W'(1));
                end
                CMD_REMOVE_AT, CMD_REMOVE_HEAD, CMD_REMOVE_TAIL: begin
                    ctl.op  = OP_REMOVE;
                    n_count = CNT_W'(cnt_w - IDX_W'(1));
                end
                CMD_REPLACE_AT: begin
                    ctl.op = OP_WRITE;
                end
                default: begin
                    ctl.op = OP_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (apply) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply) begin
            r_ok       <= n_ok;
            r_found_en <= n_found_en;
            r_rd_en    <= n_rd_en;
        end
    end

    // ---------------- row of cells ----------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] left_data;
        logic signed [31:0] right_data;

        if (g == 0) begin : g_first
            assign left_data = 32'sd0;
        end else begin : g_inner_l
            assign left_data = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_data = cell_data[g];
        end else begin : g_inner_r
            assign right_data = cell_data[g+1];
        end

        ils_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_left  (left_data),
            .i_right (right_data),
            .o_data  (cell_data[g]),
            .o_hit   (cell_hit[g]),
            .o_rd    (cell_rd[g])
        );
    end

    // Only the addressed cell presents a non-zero read value.
    always_comb begin
        rd_any = 32'sd0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_any = rd_any | cell_rd[k];
        end
    end

    // ---------------- result ----------------
    // A read of a valid position always reports found, whatever the value.
    always_comb begin
        o_res.ok         = r_ok;
        o_res.found      = r_found_en && (r_rd_en || (|cell_hit));
        o_res.read_value = r_rd_en ? rd_any : 32'sd0;
        o_res.count      = 7'(r_count);
        o_res.empty_res  = (r_count == '0);
    end

endmodule

`default_nettype wire

// ----- tb/sv/ils_checker.sv -----
// ----------------------------------------------------------------------------
// ils_checker: result predictor and comparator for the indexed list store
// Watches the command and result transfers, keeps its own copy of the list,
// and compares every result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ils_checker
    import ils_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_in  i_cmd,
    input  logic i_done,
    input  t_out i_res,
    output int   o_pending,
    output int   o_list_len,
    output int   o_fails
);

    logic signed [31:0] list_vals [ILS_DEPTH];
    int                 list_len   = 0;
    t_out               results_due[$];
    int                 result_no  = 0;
    int                 fail_count = 0;

    assign o_fails = fail_count;

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at result %0d: %s", result_no, msg);
        fail_count++;
    endtask

    function automatic bit list_insert(input int pos, input logic signed [31:0] v);
        int i;
        if (list_len >= ILS_DEPTH || pos > list_len) return 1'b0;
        for (i = list_len; i > pos; i--) list_vals[i] = list_vals[i - 1];
        list_vals[pos] = v;
        list_len++;
        return 1'b1;
    endfunction

    function automatic bit list_remove(input int pos);
        int i;
        if (pos < 0 || pos >= list_len) return 1'b0;
        for (i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
        list_len--;
        return 1'b1;
    endfunction

    task automatic predict_result(input t_in c, output t_out r);
        int pos;
        int i;
        pos = int'(c.position);
        r   = '0;
        case (c.command)
            CMD_INSERT_AT:   r.ok = list_insert(pos, c.value);
            CMD_INSERT_HEAD: r.ok = list_insert(0, c.value);
            CMD_INSERT_TAIL: r.ok = list_insert(list_len, c.value);
            CMD_REMOVE_AT:   r.ok = list_remove(pos);
            CMD_REMOVE_HEAD: r.ok = list_remove(0);
            // On an empty list this asks for position -1, which is refused.
            CMD_REMOVE_TAIL: r.ok = list_remove(list_len - 1);
            CMD_REPLACE_AT: begin
                if (pos < list_len) begin
                    list_vals[pos] = c.value;
                    r.ok = 1'b1;
                end
            end
            CMD_READ_AT: begin
                if (pos < list_len) begin
                    r.read_value = list_vals[pos];
                    r.ok         = 1'b1;
                    r.found      = 1'b1;
                end
            end
            CMD_EXISTS: begin
                if (list_len > 0) begin
                    r.ok = 1'b1;
                    for (i = 0; i < list_len; i++)
                        if (list_vals[i] == c.value) r.found = 1'b1;
                end
            end
            CMD_EQUALS: begin
                if (pos < list_len) begin
                    r.ok    = 1'b1;
                    r.found = (list_vals[pos] == c.value);
                end
            end
            CMD_CLEAR: begin
                list_len = 0;
                r.ok     = 1'b1;
            end
            default: ;
        endcase
        r.count     = 7'(list_len);
        r.empty_res = (list_len == 0);
    endtask

    // Results are checked before the command transfer of the same edge is
    // predicted, so the queue only ever holds commands that went in earlier.
    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            list_len = 0;
            results_due.delete();
        end else begin
            if (i_done) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result with no command outstanding");
                end else begin
                    want = results_due.pop_front();
                    if (i_res.ok !== want.ok)
                        report_mismatch($sformatf("ok %b, expected %b", i_res.ok, want.ok));
                    if (i_res.found !== want.found)
                        report_mismatch($sformatf("found %b, expected %b",
                                                  i_res.found, want.found));
                    if (i_res.read_value !== want.read_value)
                        report_mismatch($sformatf("read_value %0d, expected %0d",
                                                  i_res.read_value, want.read_value));
                    if (i_res.count !== want.count)
                        report_mismatch($sformatf("count %0d, expected %0d",
                                                  i_res.count, want.count));
                    if (i_res.empty_res !== want.empty_res)
                        report_mismatch($sformatf("empty_res %b, expected %b",
                                                  i_res.empty_res, want.empty_res));
                end
                result_no++;
            end
            if (i_start && !i_busy) begin
                predict_result(i_cmd, want);
                results_due.push_back(want);
            end
        end
        o_pending  <= results_due.size();
        o_list_len <= list_len;
    end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the indexed list store
// Directed corner cases, then random command streams that fill, churn and
// drain the list under several sender idling patterns; ils_checker compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import ils_pkg::*;

    localparam int          WATCHDOG_LIMIT  = 200;
    localparam int          ITEMS_PER_PHASE = 200;
    localparam int          MODE_SPAN       = 60;
    localparam logic [3:0]  CMD_UNKNOWN_LO  = 4'd11;
    localparam logic [3:0]  CMD_UNKNOWN_HI  = 4'd15;
    localparam logic signed [31:0] VAL_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX  = 32'sh7FFF_FFFF;

    typedef enum int {MODE_FILL, MODE_CHURN, MODE_DRAIN} t_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_in  cmd_bus = '0;
    logic busy;
    logic o_done;
    t_out res_bus;

    int   pending;
    int   list_len;
    int   fail_count;
    int   quiet_cycles = 0;
    int   idle_pct     = 0;
    logic signed [31:0] value_pool [8];

    always #10 i_clk = ~i_clk;

    indexed_list_store i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (cmd_bus),
        .busy    (busy),
        .o_done  (o_done),
        .o_res   (res_bus)
    );

    ils_checker i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_cmd      (cmd_bus),
        .i_done     (o_done),
        .i_res      (res_bus),
        .o_pending  (pending),
        .o_list_len (list_len),
        .o_fails    (fail_count)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic t_in make_cmd(input logic [3:0] command, input int position,
                                     input logic signed [31:0] value);
        t_in c;
        c.command  = command;
        c.position = 7'(position);
        c.value    = value;
        return c;
    endfunction

    // Called just after a rising edge; returns just after the accepting edge,
    // possibly with start lowered for a random gap.
    task automatic send_cmd(input t_in c);
        cmd_bus <= c;
        start   <= 1'b1;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Values mostly come from a small pool so that searches and compares hit.
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        if ($urandom_range(0, 99) < 60) begin
            v = value_pool[$urandom_range(0, 7)];
        end else begin
            v = $urandom;
            if ($urandom_range(0, 99) < 50) value_pool[$urandom_range(4, 7)] = v;
        end
        return v;
    endfunction

    function automatic t_in random_cmd(input t_mode mode);
        int         r;
        int         ins_w;
        int         rem_w;
        logic [3:0] command;
        int         position;
        ins_w = (mode == MODE_FILL) ? 65 : (mode == MODE_DRAIN) ? 15 : 35;
        rem_w = (mode == MODE_FILL) ? 10 : (mode == MODE_DRAIN) ? 55 : 30;
        r = $urandom_range(0, 99);
        if (r < ins_w)
            command = 4'($urandom_range(CMD_INSERT_AT, CMD_INSERT_TAIL));
        else if (r < ins_w + rem_w)
            command = 4'($urandom_range(CMD_REMOVE_AT, CMD_REMOVE_TAIL));
        else if (r < 97)
            command = 4'($urandom_range(CMD_REPLACE_AT, CMD_EQUALS));
        else if (r < 99)
            // Clearing while filling would keep the list from ever getting full.
            command = (mode == MODE_FILL) ? CMD_INSERT_TAIL : CMD_CLEAR;
        else
            command = 4'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
        if ($urandom_range(0, 99) < 80)
            position = $urandom_range(0, list_len);
        else
            position = $urandom_range(0, 127);
        return make_cmd(command, position, pick_value());
    endfunction

    initial begin : stimulus
        int n;
        int ph;
        int phase_idle [4];
        phase_idle = '{0, 51, 0, 15};
        value_pool = '{VAL_MIN, VAL_MAX, 0, -1, 1, 2, 3, 4};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Corner cases on the empty list, then a short list built at both ends.
        send_cmd(make_cmd(CMD_CLEAR, 0, 0));
        send_cmd(make_cmd(CMD_REMOVE_HEAD, 0, 0));
        send_cmd(make_cmd(CMD_REMOVE_TAIL, 0, 0));
        send_cmd(make_cmd(CMD_EXISTS, 0, 0));
        send_cmd(make_cmd(CMD_READ_AT, 0, 0));
        send_cmd(make_cmd(CMD_UNKNOWN_LO, 0, 0));
        send_cmd(make_cmd(CMD_UNKNOWN_HI, 127, -1));
        send_cmd(make_cmd(CMD_INSERT_TAIL, 0, VAL_MAX));
        send_cmd(make_cmd(CMD_INSERT_HEAD, 0, VAL_MIN));
        send_cmd(make_cmd(CMD_INSERT_AT, 2, 0));
        send_cmd(make_cmd(CMD_INSERT_AT, 4, 7));
        send_cmd(make_cmd(CMD_INSERT_AT, 1, 5));
        send_cmd(make_cmd(CMD_READ_AT, 1, 0));
        send_cmd(make_cmd(CMD_READ_AT, 4, 0));
        send_cmd(make_cmd(CMD_READ_AT, 127, 0));
        send_cmd(make_cmd(CMD_EQUALS, 0, VAL_MIN));
        send_cmd(make_cmd(CMD_EQUALS, 3, 1));
        send_cmd(make_cmd(CMD_EXISTS, 0, VAL_MAX));
        send_cmd(make_cmd(CMD_EXISTS, 0, 12345));
        send_cmd(make_cmd(CMD_REPLACE_AT, 3, -1));
        send_cmd(make_cmd(CMD_REPLACE_AT, 4, 9));
        send_cmd(make_cmd(CMD_REMOVE_AT, 127, 0));
        send_cmd(make_cmd(CMD_REMOVE_AT, 1, 0));
        send_cmd(make_cmd(CMD_REMOVE_HEAD, 0, 0));
        send_cmd(make_cmd(CMD_REMOVE_TAIL, 0, 0));

        n = 0;
        for (ph = 0; ph < 4; ph++) begin
            idle_pct = phase_idle[ph];
            repeat (ITEMS_PER_PHASE) begin
                send_cmd(random_cmd(t_mode'((n / MODE_SPAN) % 3)));
                n++;
                // Now and then hold off until every outstanding result is back.
                if (n % 50 == 0) begin
                    start <= 1'b0;
                    do @(posedge i_clk); while (pending != 0);
                end
            end
        end

        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
